[rtl/core/owm_pkg.sv]
`timescale 1ns / 1ps

package owm_pkg;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_RESET = 2'd1,
		PH_WRITE = 2'd2,
		PH_READ  = 2'd3
	} phase_t;

	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_RESET = 2'd1;
	localparam logic [1:0] MODE_WRITE = 2'd2;
	localparam logic [1:0] MODE_READ  = 2'd3;

	localparam int SLOT_W = 10;

	localparam logic [SLOT_W-1:0] RST_LOW_US    = 10'd480;
	localparam logic [SLOT_W-1:0] RST_SAMPLE_US = 10'd550;
	localparam logic [SLOT_W-1:0] RST_TOTAL_US  = 10'd960;
	localparam logic [SLOT_W-1:0] WR1_LOW_US    = 10'd6;
	localparam logic [SLOT_W-1:0] WR0_LOW_US    = 10'd60;
	localparam logic [SLOT_W-1:0] SLOT_US       = 10'd70;
	localparam logic [SLOT_W-1:0] RD_LOW_US     = 10'd6;
	localparam logic [SLOT_W-1:0] RD_SAMPLE_US  = 10'd15;

	localparam logic [2:0] LAST_BIT = 3'd7;

endpackage

[rtl/core/owm_in_if.sv]
`timescale 1ns / 1ps

interface owm_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] write_data;
	logic       line_level;

	modport source (output valid, output mode, output write_data, output line_level,
		input ready);
	modport sink (input valid, input mode, input write_data, input line_level,
		output ready);
endinterface

[rtl/core/owm_out_if.sv]
`timescale 1ns / 1ps

interface owm_out_if;
	logic       valid;
	logic       ready;
	logic       line_low;
	logic       busy_res;
	logic       done_res;
	logic       presence;
	logic [7:0] read_data;

	modport source (output valid, output line_low, output busy_res, output done_res,
		output presence, output read_data, input ready);
	modport sink (input valid, input line_low, input busy_res, input done_res,
		input presence, input read_data, output ready);
endinterface

[rtl/core/onewire_master_slot_timer_top.sv]
`timescale 1ns / 1ps

// 1-Wire bus master paced by one-microsecond tick items. Each input item is
// either a tick (with the sampled line level) or a start command for a bus
// reset, byte write or byte read; commands that arrive while a sequence runs
// are ignored but still produce a result. Every item yields exactly one result
// item in the cycle after it is accepted. It takes one item per clock while
// no result is stalled: the state update and the result logic sit in a single
// stage ahead of the output register, and input ready stays high whenever
// that register is empty or is being emptied in the same cycle. line_low in a
// result is the level to drive on the open-drain line until the next result.
module onewire_master_slot_timer_top
	import owm_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	owm_in_if.sink        in_ch,
	owm_out_if.source     out_ch
);

	phase_t              phase_q, phase_d;
	logic [SLOT_W-1:0]   slot_q, slot_d;
	logic [2:0]          bit_q, bit_d;
	logic [7:0]          sout_q, sout_d;
	logic [7:0]          sin_q, sin_d;
	logic                pres_q, pres_d;
	logic                done_d;
	logic                line_low_d;
	logic [SLOT_W-1:0]   slot_inc;

	logic                out_valid_q;
	logic                line_low_q, busy_q, done_q, pres_out_q;
	logic [7:0]          rdata_q;
	logic                accept;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;
	assign slot_inc    = slot_q + 1'b1;

	// next state
	always_comb begin
		phase_d = phase_q;
		slot_d  = slot_q;
		bit_d   = bit_q;
		sout_d  = sout_q;
		sin_d   = sin_q;
		pres_d  = pres_q;
		done_d  = 1'b0;
		if (in_ch.mode == MODE_TICK) begin
			unique case (phase_q)
				PH_IDLE: begin
				end
				PH_RESET: begin
					slot_d = slot_inc;
					if (slot_inc == RST_SAMPLE_US)
						pres_d = !in_ch.line_level;
					if (slot_inc >= RST_TOTAL_US) begin
						phase_d = PH_IDLE;
						slot_d  = '0;
						done_d  = 1'b1;
					end
				end
				PH_WRITE, PH_READ: begin
					slot_d = slot_inc;
					if (phase_q == PH_READ && slot_inc == RD_SAMPLE_US && in_ch.line_level)
						sin_d[bit_q] = 1'b1;
					if (slot_inc >= SLOT_US) begin
						slot_d = '0;
						if (bit_q == LAST_BIT) begin
							phase_d = PH_IDLE;
							bit_d   = '0;
							done_d  = 1'b1;
						end else begin
							bit_d = bit_q + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end else if (phase_q == PH_IDLE) begin
			phase_d = phase_t'(in_ch.mode);
			slot_d  = '0;
			bit_d   = '0;
			case (in_ch.mode)
				MODE_RESET: pres_d = 1'b0;
				MODE_WRITE: sout_d = in_ch.write_data;
				default:    sin_d  = '0;
			endcase
		end
	end

	// line drive from the updated state
	always_comb begin
		unique case (phase_d)
			PH_RESET: line_low_d = slot_d < RST_LOW_US;
			PH_WRITE: line_low_d = sout_d[bit_d] ? (slot_d < WR1_LOW_US)
			                                      : (slot_d < WR0_LOW_US);
			PH_READ:  line_low_d = slot_d < RD_LOW_US;
			default:  line_low_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			slot_q      <= '0;
			bit_q       <= '0;
			sout_q      <= '0;
			sin_q       <= '0;
			pres_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= phase_d;
				slot_q  <= slot_d;
				bit_q   <= bit_d;
				sout_q  <= sout_d;
				sin_q   <= sin_d;
				pres_q  <= pres_d;
			end
			if (accept)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			line_low_q <= line_low_d;
			busy_q     <= phase_d != PH_IDLE;
			done_q     <= done_d;
			pres_out_q <= pres_d;
			rdata_q    <= sin_d;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.line_low  = line_low_q;
	assign out_ch.busy_res  = busy_q;
	assign out_ch.done_res  = done_q;
	assign out_ch.presence  = pres_out_q;
	assign out_ch.read_data = rdata_q;

endmodule

[rtl/core/owm_checker.sv]
`timescale 1ns / 1ps

module owm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       line_low,
	input logic       busy_res,
	input logic       done_res,
	input logic       presence,
	input logic [7:0] read_data
);

	// every accepted item gives a result on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted item produced no result");

	// no new item while a pending result is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(line_low) && $stable(busy_res)
		&& $stable(done_res) && $stable(presence) && $stable(read_data))
		else $error("stalled result changed");

	// line is only pulled while a sequence runs; done closes the sequence
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (line_low || done_res) |-> (busy_res != done_res))
		else $error("line drive or done inconsistent with busy");

endmodule

bind onewire_master_slot_timer_top owm_checker u_owm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.line_low  (out_ch.line_low),
	.busy_res  (out_ch.busy_res),
	.done_res  (out_ch.done_res),
	.presence  (out_ch.presence),
	.read_data (out_ch.read_data)
);
